[rtl/core/cat_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// cat_pkg: shared types for the call arc counter table
// status codes, operation codes and the word that travels down the cell chain
// ============================================================================
package cat_pkg;

    localparam int ADDR_W       = 32;
    localparam int COUNT_W      = 32;
    localparam int SLOT_INDEX_W = 6;
    localparam int SLOTS_USED_W = 7;
    localparam int STATUS_W     = 3;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_HIT   = 3'd0,
        STATUS_NEW   = 3'd1,
        STATUS_FULL  = 3'd2,
        STATUS_EMPTY = 3'd3,
        STATUS_VALID = 3'd4
    } t_status;

    // query plus the result gathered so far
    typedef struct packed {
        t_op                     op;
        logic [ADDR_W-1:0]       caller;
        logic [ADDR_W-1:0]       callee;
        logic [SLOT_INDEX_W-1:0] idx;
        logic                    done;
        t_status                 status;
        logic [ADDR_W-1:0]       res_caller;
        logic [ADDR_W-1:0]       res_callee;
        logic [COUNT_W-1:0]      res_calls;
    } t_word;

endpackage

[rtl/core/cat_cell.sv]
`timescale 1ns / 1ps
// ============================================================================
// cat_cell: one arc slot of the call arc counter table
// holds one arc, serves the word passing by and hands it to the next cell
// ============================================================================
module cat_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  cat_pkg::t_word i_word,
    output logic          o_vld,
    output cat_pkg::t_word o_word
);
    import cat_pkg::*;

    // slot indexes above the input field range can never be read
    localparam bit                      READABLE = (CELL_IDX < (1 << SLOT_INDEX_W));
    localparam logic [SLOT_INDEX_W-1:0] MY_IDX   =
        SLOT_INDEX_W'(CELL_IDX % (1 << SLOT_INDEX_W));

    logic               r_valid;
    logic [ADDR_W-1:0]  r_caller;
    logic [ADDR_W-1:0]  r_callee;
    logic [COUNT_W-1:0] r_count;
    logic               r_vld;
    t_word              r_word;

    t_word              n_word;
    logic               n_insert;
    logic               n_hit;
    logic [COUNT_W-1:0] n_count;
    logic               idx_hit;
    logic               addr_hit;

    assign idx_hit  = READABLE && (i_word.idx == MY_IDX);
    assign addr_hit = (r_caller == i_word.caller) && (r_callee == i_word.callee);

    always_comb begin
        n_word   = i_word;
        n_insert = 1'b0;
        n_hit    = 1'b0;
        n_count  = (r_count == COUNT_MAX) ? r_count : r_count + 1'b1;
        if (i_vld && !i_word.done) begin
            if (i_word.op == OP_READ) begin
                if (idx_hit) begin
                    n_word.done = 1'b1;
                    if (r_valid) begin
                        n_word.status     = STATUS_VALID;
                        n_word.res_caller = r_caller;
                        n_word.res_callee = r_callee;
                        n_word.res_calls  = r_count;
                    end
                end
            end else if (r_valid) begin
                if (addr_hit) begin
                    n_hit            = 1'b1;
                    n_word.done      = 1'b1;
                    n_word.status    = STATUS_HIT;
                    n_word.res_calls = n_count;
                end
            end else begin
                // first free slot, and no earlier slot held this arc
                n_insert         = 1'b1;
                n_word.done      = 1'b1;
                n_word.status    = STATUS_NEW;
                n_word.res_calls = COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_vld <= i_vld;
            if (n_insert) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        if (n_insert) begin
            r_caller <= i_word.caller;
            r_callee <= i_word.callee;
            r_count  <= COUNT_W'(1);
        end else if (n_hit) begin
            r_count <= n_count;
        end
    end

    assign o_vld  = r_vld;
    assign o_word = r_word;

endmodule

[rtl/core/call_arc_counter_table.sv]
`timescale 1ns / 1ps
// ============================================================================
// call_arc_counter_table: call-graph arc counter
// a chain of arc slot cells; each word walks the chain once, one cell a cycle
// ============================================================================
//
//  channel   direction   handshake           payload
//  ------------------------------------------------------------------------
//  input     in          i_valid / o_ready   i_op, i_caller_addr,
//                                            i_callee_addr, i_slot_index
//  result    out         o_valid / i_ready   o_status, o_arc_caller,
//                                            o_arc_callee, o_arc_calls,
//                                            o_slots_used
//
//  one word at a time: an accepted word passes the head register, the walk
//  through the cell chain (one cell per cycle) and the pending and output
//  stages before o_valid; the next word is accepted once the previous
//  result sits in the output register, so a waiting result does not block
//  the input
//  a stalled output holds the finished result in the pending stage and keeps the input blocked
//  reset clears all slot valid marks and the fill count
//
module call_arc_counter_table #(
    parameter int ARC_SLOTS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic [cat_pkg::ADDR_W-1:0]          i_caller_addr,
    input  logic [cat_pkg::ADDR_W-1:0]          i_callee_addr,
    input  logic [cat_pkg::SLOT_INDEX_W-1:0]    i_slot_index,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [cat_pkg::STATUS_W-1:0]        o_status,
    output logic [cat_pkg::ADDR_W-1:0]          o_arc_caller,
    output logic [cat_pkg::ADDR_W-1:0]          o_arc_callee,
    output logic [cat_pkg::COUNT_W-1:0]         o_arc_calls,
    output logic [cat_pkg::SLOTS_USED_W-1:0]    o_slots_used
);
    import cat_pkg::*;

    // fill count holds 0..ARC_SLOTS
    localparam int FILL_W = $clog2(ARC_SLOTS + 1);
    localparam int EXT_W  = FILL_W + SLOTS_USED_W;

    // control
    logic                    r_busy;
    logic                    r_head_vld;
    logic                    r_pend_vld;
    logic                    r_out_vld;
    logic [FILL_W-1:0]       r_fill;

    // payload
    t_word                   r_head;
    t_word                   r_pend;
    logic [SLOTS_USED_W-1:0] r_pend_used;
    t_word                   r_out;
    logic [SLOTS_USED_W-1:0] r_out_used;

    logic                    accept;
    logic                    move;
    logic                    tail_vld;
    t_word                   tail_word;
    t_word                   n_head;
    logic [FILL_W-1:0]       n_fill;
    logic [EXT_W-1:0]        fill_ext;

    // chain taps: tap 0 is the head register, tap ARC_SLOTS the last cell
    logic                    w_vld  [0:ARC_SLOTS];
    t_word                   w_word [0:ARC_SLOTS];

    assign o_ready = !r_busy;
    assign accept  = i_valid && !r_busy;
    assign move    = r_pend_vld && (!r_out_vld || i_ready);

    // head word starts out as the answer if no cell claims it:
    // a miss on record means table full, a miss on read means empty slot
    always_comb begin
        n_head.op         = t_op'(i_op);
        n_head.caller     = i_caller_addr;
        n_head.callee     = i_callee_addr;
        n_head.idx        = i_slot_index;
        n_head.done       = 1'b0;
        n_head.res_calls  = '0;
        if (t_op'(i_op) == OP_READ) begin
            n_head.status     = STATUS_EMPTY;
            n_head.res_caller = '0;
            n_head.res_callee = '0;
        end else begin
            n_head.status     = STATUS_FULL;
            n_head.res_caller = i_caller_addr;
            n_head.res_callee = i_callee_addr;
        end
    end

    assign w_vld[0]  = r_head_vld;
    assign w_word[0] = r_head;

    for (genvar g = 0; g < ARC_SLOTS; g++) begin : g_cell
        cat_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_word  (w_word[g]),
            .o_vld   (w_vld[g+1]),
            .o_word  (w_word[g+1])
        );
    end

    assign tail_vld  = w_vld[ARC_SLOTS];
    assign tail_word = w_word[ARC_SLOTS];

    // fill count after this word
    assign n_fill   = (tail_vld && (tail_word.status == STATUS_NEW)) ?
                      r_fill + 1'b1 : r_fill;
    assign fill_ext = EXT_W'(n_fill);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_head_vld <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
            r_fill     <= '0;
        end else begin
            r_head_vld <= accept;
            r_fill     <= n_fill;
            if (accept) begin
                r_busy <= 1'b1;
            end else if (move) begin
                r_busy <= 1'b0;
            end
            if (tail_vld) begin
                r_pend_vld <= 1'b1;
            end else if (move) begin
                r_pend_vld <= 1'b0;
            end
            if (move) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_head <= n_head;
        end
        if (tail_vld) begin
            r_pend      <= tail_word;
            r_pend_used <= fill_ext[SLOTS_USED_W-1:0];
        end
        if (move) begin
            r_out      <= r_pend;
            r_out_used <= r_pend_used;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_status     = r_out.status;
    assign o_arc_caller = r_out.res_caller;
    assign o_arc_callee = r_out.res_callee;
    assign o_arc_calls  = r_out.res_calls;
    assign o_slots_used = r_out_used;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ============================================================================
// testbench: self-checking bench for the call arc counter table
// a queue of words feeds a clocked driver; a clocked monitor checks every
// result against a bench-side table model, field by field and in order.
// directed words cover empty reads, address extremes, hits and near misses;
// random words fill the table slowly with hits mixed in, then run it full.
// saturation of the call count needs about four billion hits on one arc and
// is out of reach in a run of this length
// ============================================================================
module testbench;
    import cat_pkg::*;

    localparam int SLOTS        = 64;
    localparam int RANDOM_WORDS = 1630;
    localparam int TAIL_WORDS   = 150;     // last words go out with no random idle bursts

    // one input word, plus a flag that holds it back until the table is drained
    typedef struct {
        t_op                     op;
        logic [ADDR_W-1:0]       caller;
        logic [ADDR_W-1:0]       callee;
        logic [SLOT_INDEX_W-1:0] idx;
        bit                      drain_first;
    } t_arc_word;

    // one result word as the block should present it
    typedef struct {
        t_status                 status;
        logic [ADDR_W-1:0]       caller;
        logic [ADDR_W-1:0]       callee;
        logic [COUNT_W-1:0]      calls;
        logic [SLOTS_USED_W-1:0] used;
    } t_arc_result;

    // clock, reset and block ports; the driven inputs are known from time zero
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    i_valid       = 1'b0;
    logic                    o_ready;
    logic                    i_op          = 1'b0;
    logic [ADDR_W-1:0]       i_caller_addr = '0;
    logic [ADDR_W-1:0]       i_callee_addr = '0;
    logic [SLOT_INDEX_W-1:0] i_slot_index  = '0;
    logic                    o_valid;
    logic                    i_ready       = 1'b0;
    logic [STATUS_W-1:0]     o_status;
    logic [ADDR_W-1:0]       o_arc_caller;
    logic [ADDR_W-1:0]       o_arc_callee;
    logic [COUNT_W-1:0]      o_arc_calls;
    logic [SLOTS_USED_W-1:0] o_slots_used;

    // words waiting to be sent, and results waiting to come back
    t_arc_word   pending_words[$];
    t_arc_result awaited_results[$];
    t_arc_word   cur_word;

    // arcs the generator has introduced, in the order they should fill slots
    logic [ADDR_W-1:0] known_callers[$];
    logic [ADDR_W-1:0] known_callees[$];

    // bench copy of the arc table
    logic [ADDR_W-1:0]  tbl_caller[SLOTS];
    logic [ADDR_W-1:0]  tbl_callee[SLOTS];
    logic [COUNT_W-1:0] tbl_calls[SLOTS];
    bit                 tbl_live[SLOTS];
    int unsigned        tbl_fill = 0;

    int words_sent   = 0;     // driver only
    int results_seen = 0;     // monitor only, nonblocking
    int errors       = 0;
    int gap_left     = 0;
    int stall_left   = 0;
    bit quiet_tail   = 1'b0;

    always #6 i_clk = ~i_clk;

    call_arc_counter_table #(
        .ARC_SLOTS     (SLOTS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_caller_addr (i_caller_addr),
        .i_callee_addr (i_callee_addr),
        .i_slot_index  (i_slot_index),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_arc_caller  (o_arc_caller),
        .o_arc_callee  (o_arc_callee),
        .o_arc_calls   (o_arc_calls),
        .o_slots_used  (o_slots_used)
    );

    // table update for one accepted word; returns the result it must produce
    function automatic t_arc_result update_arc_table(input t_arc_word w);
        t_arc_result r;
        int          hit;
        hit      = -1;
        r.status = STATUS_EMPTY;
        r.caller = '0;
        r.callee = '0;
        r.calls  = '0;
        if (w.op == OP_READ) begin
            if (w.idx < SLOTS && tbl_live[w.idx]) begin
                r.status = STATUS_VALID;
                r.caller = tbl_caller[w.idx];
                r.callee = tbl_callee[w.idx];
                r.calls  = tbl_calls[w.idx];
            end
        end else begin
            r.caller = w.caller;
            r.callee = w.callee;
            // both addresses must match; first live match wins
            for (int s = 0; s < SLOTS; s++) begin
                if (hit < 0 && tbl_live[s] && tbl_caller[s] == w.caller
                        && tbl_callee[s] == w.callee)
                    hit = s;
            end
            if (hit >= 0) begin
                if (tbl_calls[hit] != COUNT_MAX)
                    tbl_calls[hit] = tbl_calls[hit] + 1'b1;
                r.status = STATUS_HIT;
                r.calls  = tbl_calls[hit];
            end else if (tbl_fill >= SLOTS) begin
                // table full: arc dropped, pair echoed, zero count
                r.status = STATUS_FULL;
            end else begin
                tbl_caller[tbl_fill] = w.caller;
                tbl_callee[tbl_fill] = w.callee;
                tbl_calls[tbl_fill]  = COUNT_W'(1);
                tbl_live[tbl_fill]   = 1'b1;
                tbl_fill++;
                r.status = STATUS_NEW;
                r.calls  = COUNT_W'(1);
            end
        end
        r.used = tbl_fill[SLOTS_USED_W-1:0];
        return r;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    // record word; the unused index gets random bits
    task automatic push_record(input logic [ADDR_W-1:0] a, b, input bit drain);
        t_arc_word w;
        w.op          = OP_RECORD;
        w.caller      = a;
        w.callee      = b;
        w.idx         = SLOT_INDEX_W'($urandom_range(0, 2**SLOT_INDEX_W - 1));
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // record word for an arc not seen before
    task automatic push_new_arc(input logic [ADDR_W-1:0] a, b, input bit drain);
        known_callers.push_back(a);
        known_callees.push_back(b);
        push_record(a, b, drain);
    endtask

    // read word; the unused addresses get random bits
    task automatic push_read(input logic [SLOT_INDEX_W-1:0] i, input bit drain);
        t_arc_word w;
        w.op          = OP_READ;
        w.caller      = $urandom;
        w.callee      = $urandom;
        w.idx         = i;
        w.drain_first = drain;
        pending_words.push_back(w);
    endtask

    // driver: payload changes only when the slot is free (idle or just taken)
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            // word taken at this edge: advance the bench table
            if (i_valid && o_ready) begin
                awaited_results.push_back(update_arc_table(cur_word));
                words_sent++;
            end
            quiet_tail <= (pending_words.size() < TAIL_WORDS);
            if (!i_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() == 0) begin
                    i_valid <= 1'b0;
                end else if (pending_words[0].drain_first && results_seen != words_sent) begin
                    // hold off until every result is back
                    i_valid <= 1'b0;
                end else if (pending_words.size() >= TAIL_WORDS
                        && $urandom_range(0, 5) == 0) begin
                    // idle burst, its length drawn at random into gap_left
                    gap_left = $urandom_range(0, 2);
                    i_valid <= 1'b0;
                end else begin
                    cur_word = pending_words.pop_front();
                    i_op          <= cur_word.op;
                    i_caller_addr <= cur_word.caller;
                    i_callee_addr <= cur_word.callee;
                    i_slot_index  <= cur_word.idx;
                    i_valid       <= 1'b1;
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest expectation
    always @(posedge i_clk) begin : monitor
        t_arc_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen <= results_seen + 1;
                if (awaited_results.size() == 0) begin
                    flag_error($sformatf("result %0d arrived with none expected",
                                         results_seen));
                end else begin
                    want = awaited_results.pop_front();
                    if (o_status !== want.status)
                        flag_error($sformatf("result %0d status %0d, expected %0d",
                                             results_seen, o_status, want.status));
                    if (o_arc_caller !== want.caller)
                        flag_error($sformatf("result %0d caller %h, expected %h",
                                             results_seen, o_arc_caller, want.caller));
                    if (o_arc_callee !== want.callee)
                        flag_error($sformatf("result %0d callee %h, expected %h",
                                             results_seen, o_arc_callee, want.callee));
                    if (o_arc_calls !== want.calls)
                        flag_error($sformatf("result %0d calls %h, expected %h",
                                             results_seen, o_arc_calls, want.calls));
                    if (o_slots_used !== want.used)
                        flag_error($sformatf("result %0d slots used %0d, expected %0d",
                                             results_seen, o_slots_used, want.used));
                end
            end
            // receiver stalls in bursts, their length drawn at random into stall_left, none in the tail
            if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 2);
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] b;
        int                known;
        int                pick;
        int                roll;
        int                total;
        bit                drain;

        // directed: empty reads at both ends of the index range
        push_read('0, 1'b0);
        push_read(SLOT_INDEX_W'(SLOTS - 1), 1'b0);
        // address extremes, a repeat hit and partial matches on one side
        push_new_arc('0, '0, 1'b0);
        push_record('0, '0, 1'b0);
        push_new_arc('1, '1, 1'b0);
        push_new_arc('1, '0, 1'b0);
        push_new_arc('0, '1, 1'b0);
        push_record('1, '1, 1'b0);
        push_record('0, '0, 1'b0);
        // alternating bit patterns, each way round
        push_new_arc(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        push_new_arc(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        push_record(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        // read back filled slots and a few still empty
        push_read(6'd0, 1'b0);
        push_read(6'd1, 1'b0);
        push_read(6'd4, 1'b0);
        push_read(6'd5, 1'b0);
        push_read(6'd6, 1'b0);
        push_read(6'h2A, 1'b0);
        push_read(SLOT_INDEX_W'(SLOTS - 1), 1'b0);

        // random: new arcs are rare so the table fills over most of the run,
        // then records of fresh pairs hit the full-table path
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            drain = (n == 0) || ($urandom_range(0, 399) == 0);
            roll  = $urandom_range(0, 99);
            known = (known_callers.size() < SLOTS) ? known_callers.size() : SLOTS;
            if (roll < 6) begin
                a = $urandom;
                b = $urandom;
                // near miss: share one address with a stored arc
                if ($urandom_range(0, 3) == 0)
                    a = known_callers[$urandom_range(0, known - 1)];
                else if ($urandom_range(0, 2) == 0)
                    b = known_callees[$urandom_range(0, known - 1)];
                push_new_arc(a, b, drain);
            end else if (roll < 62) begin
                pick = $urandom_range(0, known - 1);
                push_record(known_callers[pick], known_callees[pick], drain);
            end else if (roll < 66 && known_callers.size() > SLOTS) begin
                // repeat of an arc that was dropped while the table was full
                pick = $urandom_range(SLOTS, known_callers.size() - 1);
                push_record(known_callers[pick], known_callees[pick], drain);
            end else begin
                push_read(SLOT_INDEX_W'($urandom_range(0, SLOTS - 1)), drain);
            end
        end
        total = pending_words.size();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(posedge i_clk);
        while (pending_words.size() != 0 || results_seen != total);
        repeat (SLOTS + 8) @(posedge i_clk);

        if (awaited_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", awaited_results.size()));

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog: ends a run that hangs
    initial begin : watchdog
        #12_000_000;
        $display("ERROR: timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
